FILE: hw/rtl/qlb_pkg.sv
package qlb_pkg;

    localparam int CHAR_W       = 8;
    localparam int COL_W        = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_QUOTE_MAP_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE_MAP_MID_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE_MAP_MID_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE_MAP_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_LIMIT       = 3'd4;

    localparam logic [CFG_DATA_W-1:0] QUOTE_MAP_LOW_RST      = 64'h4000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] QUOTE_MAP_MID_LOW_RST  = 64'h1000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] QUOTE_MAP_MID_HIGH_RST = 64'h0;
    localparam logic [CFG_DATA_W-1:0] QUOTE_MAP_HIGH_RST     = 64'h0;
    localparam logic [COL_W-1:0]      MARGIN_LIMIT_RST       = 6'd10;

    typedef enum logic {
        CMD_HOLD = 1'b0,
        CMD_EMIT = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] ch;
        logic              blank_held;
        logic              blank_cur;
    } cmd_t;

endpackage

FILE: hw/rtl/qlb_front.sv
module qlb_front #(
    parameter int HOLD_DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [qlb_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [qlb_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [qlb_pkg::CHAR_W-1:0]     s_char,
    input  logic                           s_last,
    output logic                           push_valid,
    input  logic                           push_ready,
    output qlb_pkg::cmd_t                  push_cmd
);
    import qlb_pkg::*;

    localparam int HOLD_AW = $clog2(HOLD_DEPTH);

    logic [3:0][CFG_DATA_W-1:0] quote_map_reg;
    logic [COL_W-1:0]           margin_reg;

    logic               at_start_reg, at_start_next;
    logic               quoted_reg, quoted_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [HOLD_AW-1:0] held_reg, held_next;

    logic accept;
    logic hit;
    logic quoted_now;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    assign hit        = quote_map_reg[s_char[7:6]][s_char[5:0]];
    assign quoted_now = quoted_reg || (at_start_reg && hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quote_map_reg[0] <= QUOTE_MAP_LOW_RST;
            quote_map_reg[1] <= QUOTE_MAP_MID_LOW_RST;
            quote_map_reg[2] <= QUOTE_MAP_MID_HIGH_RST;
            quote_map_reg[3] <= QUOTE_MAP_HIGH_RST;
            margin_reg       <= MARGIN_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_QUOTE_MAP_LOW:      quote_map_reg[0] <= cfg_wr_data;
                REG_QUOTE_MAP_MID_LOW:  quote_map_reg[1] <= cfg_wr_data;
                REG_QUOTE_MAP_MID_HIGH: quote_map_reg[2] <= cfg_wr_data;
                REG_QUOTE_MAP_HIGH:     quote_map_reg[3] <= cfg_wr_data;
                REG_MARGIN_LIMIT:       margin_reg <= cfg_wr_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        at_start_next       = at_start_reg;
        quoted_next         = quoted_reg;
        col_next            = col_reg;
        held_next           = held_reg;
        push_cmd.kind       = CMD_EMIT;
        push_cmd.ch         = s_char;
        push_cmd.blank_held = 1'b0;
        push_cmd.blank_cur  = 1'b0;

        if (s_char == NL_CODE) begin
            push_cmd.blank_held = quoted_now;
            quoted_next         = 1'b0;
            at_start_next       = 1'b1;
            col_next            = '0;
            held_next           = '0;
        end else begin
            quoted_next = quoted_now;
            if (at_start_reg) begin
                if (col_reg < margin_reg) begin
                    col_next = col_reg + 1'b1;
                end else begin
                    at_start_next = 1'b0;
                end
            end
            if (quoted_now) begin
                push_cmd.blank_held = 1'b1;
                push_cmd.blank_cur  = 1'b1;
                held_next           = '0;
            end else if (!at_start_next || s_last ||
                         held_reg == HOLD_AW'(HOLD_DEPTH - 1)) begin
                held_next = '0;
            end else begin
                push_cmd.kind = CMD_HOLD;
                held_next     = held_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg <= 1'b1;
            quoted_reg   <= 1'b0;
            col_reg      <= '0;
            held_reg     <= '0;
        end else if (accept) begin
            at_start_reg <= at_start_next;
            quoted_reg   <= quoted_next;
            col_reg      <= col_next;
            held_reg     <= held_next;
        end
    end

endmodule

FILE: hw/rtl/qlb_queue.sv
module qlb_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  qlb_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output qlb_pkg::cmd_t pop_cmd
);
    import qlb_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                push;
    logic                pop;

    assign push_ready = count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

FILE: hw/rtl/qlb_back.sv
module qlb_back #(
    parameter int HOLD_DEPTH = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  qlb_pkg::cmd_t              pop_cmd,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [qlb_pkg::CHAR_W-1:0] m_char,
    output logic                       m_blanked,
    output logic                       m_last
);
    import qlb_pkg::*;

    localparam int HOLD_AW = $clog2(HOLD_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FLUSH = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [HOLD_AW-1:0] cnt_reg, cnt_next;
    logic [HOLD_AW-1:0] idx_reg, idx_next;
    cmd_t               cmd_reg, cmd_next;

    logic [CHAR_W-1:0]  mem [HOLD_DEPTH];
    logic [CHAR_W-1:0]  rd_data_reg;
    logic               mem_we;

    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg, m_char_next;
    logic              m_blank_reg, m_blank_next;
    logic              m_last_reg, m_last_next;
    logic              out_free;

    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_char    = m_char_reg;
    assign m_blanked = m_blank_reg;
    assign m_last    = m_last_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        cmd_next     = cmd_reg;
        pop_ready    = 1'b0;
        mem_we       = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_char_next  = m_char_reg;
        m_blank_next = m_blank_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (pop_valid) begin
                    if (pop_cmd.kind == CMD_HOLD) begin
                        pop_ready = 1'b1;
                        mem_we    = 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                    end else if (cnt_reg != '0) begin
                        pop_ready  = 1'b1;
                        cmd_next   = pop_cmd;
                        idx_next   = '0;
                        state_next = S_FLUSH;
                    end else if (out_free) begin
                        pop_ready    = 1'b1;
                        m_valid_next = 1'b1;
                        m_char_next  = pop_cmd.blank_cur ? SPACE_CODE : pop_cmd.ch;
                        m_blank_next = pop_cmd.blank_cur;
                        m_last_next  = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = cmd_reg.blank_held ? SPACE_CODE : rd_data_reg;
                    m_blank_next = cmd_reg.blank_held;
                    m_last_next  = 1'b0;
                    if (idx_reg == cnt_reg - 1'b1) begin
                        cnt_next   = '0;
                        idx_next   = '0;
                        state_next = S_EMIT;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = cmd_reg.blank_cur ? SPACE_CODE : cmd_reg.ch;
                    m_blank_next = cmd_reg.blank_cur;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cnt_reg] <= pop_cmd.ch;
        end
        rd_data_reg <= mem[idx_next];
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        m_char_reg  <= m_char_next;
        m_blank_reg <= m_blank_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_flush_has_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FLUSH |-> cnt_reg != '0 && idx_reg < cnt_reg)
        else $error("flush index outside held entries");

    a_idle_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> idx_reg == '0)
        else $error("read index not parked at zero");

    a_direct_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE && pop_valid && pop_ready && pop_cmd.kind == CMD_EMIT &&
        cnt_reg == '0 |=> m_tvalid && m_last)
        else $error("direct emit did not reach output");

    a_hold_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> cnt_reg != HOLD_AW'(HOLD_DEPTH - 1))
        else $error("hold store overflow");

endmodule

FILE: hw/rtl/quoted_line_blanker_core.sv
// Path: an item emitted directly passes the command queue and the output register when the
// back end is idle; a release of held items passes the queue, hold memory read and output register.
// Throughput: one item per cycle enters while the 4-entry command queue has room;
// the back end gives one result per cycle while the output is not stalled, and a release
// runs through the flush sequencer, which emits the held items before the releasing item.
// Reset: synchronous, clears line state, counts, queue and config to defaults.
module quoted_line_blanker_core #(
    parameter int HOLD_DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [qlb_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [qlb_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] in_char
    input  logic                           s_tlast,  // end_of_chunk
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,  // [7:0] out_char
    output logic                           m_tuser,  // was_blanked
    output logic                           m_tlast   // run_last
);
    import qlb_pkg::*;

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop_ready;
    cmd_t pop_cmd;

    qlb_front #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_char      (s_tdata),
        .s_last      (s_tlast),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    qlb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd)
    );

    qlb_back #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_cmd  (pop_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_char   (m_tdata),
        .m_blanked(m_tuser),
        .m_last   (m_tlast)
    );

endmodule
